// ----- hdl/efb_pkg.sv -----
// Shared types and constants of the escaped frame builder.
`timescale 1ns / 1ps
`default_nettype none
package efb_pkg;

  localparam int unsigned CfgIdxW = 8;

  localparam logic [CfgIdxW-1:0] CfgIdxFrameFlag  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgIdxEscapeByte = CfgIdxW'(1);

  localparam logic [7:0] FrameFlagReset  = 8'h7E;
  localparam logic [7:0] EscapeByteReset = 8'h7D;

  localparam logic [7:0] FlagCode   = 8'h02;
  localparam logic [7:0] EscapeCode = 8'h01;

  // step slots of one job, emitted lowest first
  localparam int unsigned StepOpen   = 0;
  localparam int unsigned StepData0  = 1;
  localparam int unsigned StepData1  = 2;
  localparam int unsigned StepCheck0 = 3;
  localparam int unsigned StepCheck1 = 4;
  localparam int unsigned StepClose  = 5;
  localparam int unsigned NumSteps   = 6;

  typedef logic [NumSteps-1:0] efb_steps_t;

  typedef struct packed {
    efb_steps_t steps;
    logic [7:0] data_first;
    logic [7:0] data_second;
    logic [7:0] check_first;
    logic [7:0] check_second;
  } efb_job_t;

endpackage
`default_nettype wire

// ----- hdl/efb_intf.sv -----
// Channel interfaces: input words, output words, register writes.
`timescale 1ns / 1ps
`default_nettype none
interface efb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_in;
  modport source (output valid, output data_byte, output last_in, input ready);
  modport sink (input valid, input data_byte, input last_in, output ready);
endinterface

interface efb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_out;
  modport source (output valid, output out_byte, output last_out, input ready);
  modport sink (input valid, input out_byte, input last_out, output ready);
endinterface

interface efb_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] reg_index;
  logic [7:0] wdata;
  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface
`default_nettype wire

// ----- hdl/efb_front.sv -----
// Front end: takes message words, tracks frame and check, builds output jobs.
`timescale 1ns / 1ps
`default_nettype none
module efb_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  efb_in_if.sink                in_i,
  input  wire logic [7:0]       frame_flag_i,
  input  wire logic [7:0]       escape_byte_i,
  output efb_pkg::efb_job_t     job_o,
  output logic                  job_valid_o,
  input  wire logic             job_ready_i
);
  import efb_pkg::*;

  logic [7:0] check_q, check_d;
  logic       in_frame_q, in_frame_d;
  logic [7:0] check_next;
  logic       fire;
  logic       data_is_flag, data_is_esc, chk_is_flag, chk_is_esc;

  assign fire        = in_i.valid && job_ready_i;
  assign in_i.ready  = job_ready_i;
  assign job_valid_o = in_i.valid;
  assign check_next  = check_q ^ in_i.data_byte;

  assign data_is_flag = (in_i.data_byte == frame_flag_i);
  assign data_is_esc  = (in_i.data_byte == escape_byte_i);
  assign chk_is_flag  = (check_next == frame_flag_i);
  assign chk_is_esc   = (check_next == escape_byte_i);

  always_comb begin
    job_o.steps              = '0;
    job_o.steps[StepOpen]    = !in_frame_q;
    job_o.steps[StepData0]   = 1'b1;
    job_o.steps[StepData1]   = data_is_flag || data_is_esc;
    job_o.steps[StepCheck0]  = in_i.last_in;
    job_o.steps[StepCheck1]  = in_i.last_in && (chk_is_flag || chk_is_esc);
    job_o.steps[StepClose]   = in_i.last_in;
    job_o.data_first   = (data_is_flag || data_is_esc) ? escape_byte_i : in_i.data_byte;
    job_o.data_second  = data_is_flag ? FlagCode : EscapeCode;
    job_o.check_first  = (chk_is_flag || chk_is_esc) ? escape_byte_i : check_next;
    job_o.check_second = chk_is_flag ? FlagCode : EscapeCode;
  end

  always_comb begin
    check_d    = check_q;
    in_frame_d = in_frame_q;
    if (fire) begin
      if (in_i.last_in) begin
        check_d    = '0;
        in_frame_d = 1'b0;
      end else begin
        check_d    = check_next;
        in_frame_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      check_q    <= '0;
      in_frame_q <= 1'b0;
    end else begin
      check_q    <= check_d;
      in_frame_q <= in_frame_d;
    end
  end

  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && in_i.last_in |=> !in_frame_q && check_q == 8'h00)
    else $error("frame state not cleared after last word");

  a_open_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !in_i.last_in |=> in_frame_q)
    else $error("frame not marked open after a non-last word");

endmodule
`default_nettype wire

// ----- hdl/efb_queue.sv -----
// Two-entry job queue between front end and back end.
`timescale 1ns / 1ps
`default_nettype none
module efb_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  efb_pkg::efb_job_t       push_job_i,
  input  wire logic               push_valid_i,
  output logic                    push_ready_o,
  output efb_pkg::efb_job_t       pop_job_o,
  output logic                    pop_valid_o,
  input  wire logic               pop_ready_i
);
  import efb_pkg::*;

  efb_job_t   mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_job_o    = mem_q[rd_ptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) cnt_d = cnt_q + 2'd1;
    else if (pop && !push) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop) rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_d;
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3 && (wr_ptr_q ^ rd_ptr_q) == cnt_q[0])
    else $error("queue count and pointers disagree");

endmodule
`default_nettype wire

// ----- hdl/efb_back.sv -----
// Back end: walks the steps of each job and drives the output register.
`timescale 1ns / 1ps
`default_nettype none
module efb_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  efb_pkg::efb_job_t       job_i,
  input  wire logic               job_valid_i,
  output logic                    job_ready_o,
  input  wire logic [7:0]         frame_flag_i,
  efb_out_if.source               out_o
);
  import efb_pkg::*;

  efb_steps_t done_q, done_d;
  efb_steps_t pending, cur, left;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic       out_last_q;
  logic [7:0] sel_byte;
  logic       advance;

  assign pending = job_i.steps & ~done_q;
  assign cur     = pending & (~pending + efb_steps_t'(1));
  assign left    = pending & ~cur;
  assign advance = job_valid_i && (!out_valid_q || out_o.ready);
  assign job_ready_o = advance && (left == '0);

  always_comb begin
    sel_byte = frame_flag_i;
    case (1'b1)
      cur[StepData0]:  sel_byte = job_i.data_first;
      cur[StepData1]:  sel_byte = job_i.data_second;
      cur[StepCheck0]: sel_byte = job_i.check_first;
      cur[StepCheck1]: sel_byte = job_i.check_second;
      default:         sel_byte = frame_flag_i;
    endcase
  end

  always_comb begin
    done_d      = done_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_o.ready) out_valid_d = 1'b0;
    if (advance) begin
      out_valid_d = 1'b1;
      done_d      = (left == '0) ? '0 : (done_q | cur);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_byte_q <= sel_byte;
      out_last_q <= cur[StepClose];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.out_byte = out_byte_q;
  assign out_o.last_out = out_last_q;

  a_one_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_i |-> $onehot(cur))
    else $error("no single step selected for a pending job");

  a_close_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && cur[StepClose] |-> job_ready_o)
    else $error("closing flag is not the final step of its job");

  a_done_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !job_valid_i |-> done_q == '0)
    else $error("step progress held without a job");

endmodule
`default_nettype wire

// ----- hdl/escaped_frame_builder_xor_check_unit.sv -----
// Top level of the escaped frame builder with XOR check byte.
//
//  channel  dir  payload              accepted when
//  in_i     in   data_byte, last_in   valid && ready
//  out_o    out  out_byte, last_out   valid && ready
//  cfg_i    in   reg_index, wdata     valid && ready (ready always high)
//
// Each word yields 1 to 6 output words from the output register, one per
// cycle while out_o is not stalled. A word is accepted whenever the two-entry
// job queue has room; the back end sets throughput.
// Reset clears frame state, check, queue and output valid; registers take 7E/7D.
// Output stalls hold the back end only; the front keeps taking words until
// the queue fills.
`timescale 1ns / 1ps
`default_nettype none
module escaped_frame_builder_xor_check_unit (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  efb_in_if.sink     in_i,
  efb_out_if.source  out_o,
  efb_cfg_if.sink    cfg_i
);
  import efb_pkg::*;

  logic [7:0] frame_flag_q;
  logic [7:0] escape_byte_q;
  efb_job_t   front_job, back_job;
  logic       front_valid, front_ready, back_valid, back_ready;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_flag_q  <= FrameFlagReset;
      escape_byte_q <= EscapeByteReset;
    end else if (cfg_i.valid) begin
      if (cfg_i.reg_index == CfgIdxFrameFlag) frame_flag_q <= cfg_i.wdata;
      if (cfg_i.reg_index == CfgIdxEscapeByte) escape_byte_q <= cfg_i.wdata;
    end
  end

  efb_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .frame_flag_i  (frame_flag_q),
    .escape_byte_i (escape_byte_q),
    .job_o         (front_job),
    .job_valid_o   (front_valid),
    .job_ready_i   (front_ready)
  );

  efb_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_job_i   (front_job),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_job_o    (back_job),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready)
  );

  efb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_i        (back_job),
    .job_valid_i  (back_valid),
    .job_ready_o  (back_ready),
    .frame_flag_i (frame_flag_q),
    .out_o        (out_o)
  );

endmodule
`default_nettype wire
